/* rtl/hbkd_pkg.sv */
// hbkd_pkg: shared types and constants for the hid boot report key differ
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package hbkd_pkg;

  typedef logic [7:0] code_t;
  typedef logic [6:0] len_t;

  localparam int unsigned MAX_SLOTS       = 6;
  localparam int unsigned KEY_SLOTS_DEF   = 6;
  localparam len_t        MIN_REPORT_LEN  = 7'd8;
  localparam code_t       ERR_LIMIT_RESET = 8'h03;
  localparam code_t       NO_MODIFIERS    = 8'h00;
  localparam logic        EV_PRESS        = 1'b0;
  localparam logic        EV_RELEASE      = 1'b1;

endpackage

`default_nettype wire

/* rtl/hbkd_in_if.sv */
// hbkd_in_if: report request channel, valid/ready with the boot report fields
// depends on hbkd_pkg
`default_nettype none

interface hbkd_in_if import hbkd_pkg::*; ();
  logic  valid;
  logic  ready;
  len_t  report_length;
  code_t modifier_bits;
  code_t slot_code_0;
  code_t slot_code_1;
  code_t slot_code_2;
  code_t slot_code_3;
  code_t slot_code_4;
  code_t slot_code_5;

  modport source (
    output valid, report_length, modifier_bits,
           slot_code_0, slot_code_1, slot_code_2, slot_code_3, slot_code_4, slot_code_5,
    input  ready
  );
  modport sink (
    input  valid, report_length, modifier_bits,
           slot_code_0, slot_code_1, slot_code_2, slot_code_3, slot_code_4, slot_code_5,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/hbkd_out_if.sv */
// hbkd_out_if: key event request channel, valid/ready with the event fields
// depends on hbkd_pkg
`default_nettype none

interface hbkd_out_if import hbkd_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t event_key;
  logic  event_release;
  code_t event_modifiers;
  logic  event_last;

  modport source (
    output valid, event_key, event_release, event_modifiers, event_last,
    input  ready
  );
  modport sink (
    input  valid, event_key, event_release, event_modifiers, event_last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/hid_boot_report_key_diff_top.sv */
// hid_boot_report_key_diff_top: press/release differ for boot keyboard reports
// depends on hbkd_pkg, hbkd_in_if, hbkd_out_if
// path: input register, then event register; a busy event register stalls input
// throughput: a report holds the event register until its events (up to 2*KEY_SLOTS)
//   are all taken; reports with no events pass one per cycle
// reset: synchronous active low; held codes cleared, error limit set to 3
`default_nettype none

module hid_boot_report_key_diff_top import hbkd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire code_t cfg_wr_data,
  hbkd_in_if.sink    in_ch,
  hbkd_out_if.source out_ch
);

  localparam int unsigned EV_N = 2 * KEY_SLOTS;

  // configuration
  code_t lim_r;

  // input register
  logic                        s1_valid_r;
  code_t                       s1_mods_r;
  logic [KEY_SLOTS-1:0][7:0]   s1_codes_r;

  // held codes of the last accepted report
  logic [KEY_SLOTS-1:0][7:0]   held_r;

  // event register: bit 2i is release of slot i, bit 2i+1 press of slot i
  logic [EV_N-1:0]             s2_mask_r;
  logic [KEY_SLOTS-1:0][7:0]   s2_rel_key_r;
  logic [KEY_SLOTS-1:0][7:0]   s2_prs_key_r;
  code_t                       s2_mods_r;

  logic [MAX_SLOTS-1:0][7:0]   fresh;
  logic [EV_N-1:0]             ev_mask;
  logic [EV_N-1:0]             lowest;
  logic                        in_fire;
  logic                        out_fire;
  logic                        out_last;
  logic                        s2_free;
  logic                        s1_go;
  logic                        s1_load;
  logic                        long_report;

  assign fresh[0] = in_ch.slot_code_0;
  assign fresh[1] = in_ch.slot_code_1;
  assign fresh[2] = in_ch.slot_code_2;
  assign fresh[3] = in_ch.slot_code_3;
  assign fresh[4] = in_ch.slot_code_4;
  assign fresh[5] = in_ch.slot_code_5;

  assign long_report = (in_ch.report_length >= MIN_REPORT_LEN);

  // compare the pending report against the held codes
  always_comb begin
    logic rel_hit;
    logic prs_hit;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rel_hit = 1'b0;
      prs_hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (held_r[i] == s1_codes_r[j]) rel_hit = 1'b1;
        if (s1_codes_r[i] == held_r[j]) prs_hit = 1'b1;
      end
      ev_mask[2*i]   = (held_r[i] > lim_r) && !rel_hit;
      ev_mask[2*i+1] = (s1_codes_r[i] > lim_r) && !prs_hit;
    end
  end

  // next event to show is the lowest pending bit
  assign lowest   = s2_mask_r & (~s2_mask_r + EV_N'(1));
  assign out_last = ((s2_mask_r & ~lowest) == '0);

  always_comb begin
    out_ch.event_key       = '0;
    out_ch.event_release   = EV_PRESS;
    out_ch.event_modifiers = NO_MODIFIERS;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (lowest[2*k]) begin
        out_ch.event_key       = s2_rel_key_r[k];
        out_ch.event_release   = EV_RELEASE;
        out_ch.event_modifiers = NO_MODIFIERS;
      end
      if (lowest[2*k+1]) begin
        out_ch.event_key       = s2_prs_key_r[k];
        out_ch.event_release   = EV_PRESS;
        out_ch.event_modifiers = s2_mods_r;
      end
    end
  end

  assign out_ch.valid      = (s2_mask_r != '0);
  assign out_ch.event_last = out_last;
  assign out_fire          = out_ch.valid && out_ch.ready;

  assign s2_free  = (s2_mask_r == '0) || (out_fire && out_last);
  // a report with no events only updates the held codes
  assign s1_go    = s1_valid_r && (s2_free || (ev_mask == '0));
  assign s1_load  = s1_go && (ev_mask != '0);

  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= ERR_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  // short reports are taken and dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= long_report;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mods_r  <= in_ch.modifier_bits;
      s1_codes_r <= fresh[KEY_SLOTS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s1_go) begin
      held_r <= s1_codes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= '0;
    end else if (s1_load) begin
      s2_mask_r <= ev_mask;
    end else if (out_fire) begin
      s2_mask_r <= s2_mask_r & ~lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s2_rel_key_r <= held_r;
      s2_prs_key_r <= s1_codes_r;
      s2_mods_r    <= s1_mods_r;
    end
  end

  // held codes move only when a pending report is consumed
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> $stable(held_r))
    else $error("held codes changed without a consumed report");

  // a new event set never overwrites events still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |-> ((s2_mask_r == '0) || (out_fire && out_last)))
    else $error("event register loaded while busy");

  // a pending report that cannot move stays pending
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> s1_valid_r)
    else $error("pending report lost");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for hid_boot_report_key_diff_top, a directed table then
// random boot reports across several error limits, events checked against a local differ
// depends on hbkd_pkg, hbkd_in_if, hbkd_out_if and the top level
`timescale 1ns / 1ps

module testbench import hbkd_pkg::*; ();

  localparam int NUM_SLOTS    = KEY_SLOTS_DEF;
  localparam int FROM_MODEL   = -1;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 23;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_DIR      = 19;

  typedef struct packed {
    len_t             len;
    code_t            mods;
    logic [0:5][7:0]  slots;
  } report_t;

  typedef struct packed {
    code_t key;
    logic  rel;
    code_t mods;
    logic  last;
  } exp_event_t;

  typedef enum logic {ROW_REPORT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    code_t           cfg_value;
    len_t            len;
    code_t           mods;
    logic [0:5][7:0] slots;
    int              fixed_n;
    code_t           fixed_key;
    logic            fixed_rel;
    code_t           fixed_mods;
  } row_t;

  // fixed_n of 0 or 1 gives the events by hand, FROM_MODEL leaves them to the differ
  row_t dir_rows [NUM_DIR] = '{
    '{ROW_REPORT, 8'h00, 7'd7,   8'h00, 48'h10_00_00_00_00_00, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'hFF, 48'h04_00_00_00_00_00, 1, 8'h04, EV_PRESS, 8'hFF},
    '{ROW_REPORT, 8'h00, 7'd64,  8'h00, 48'h00_00_00_00_00_00, 1, 8'h04, EV_RELEASE,
      NO_MODIFIERS},
    '{ROW_REPORT, 8'h00, 7'd0,   8'hFF, 48'hFF_FF_FF_FF_FF_FF, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd127, 8'hA5, 48'hFF_04_05_06_07_08, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h3C, 48'h04_05_06_07_08_FF, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h5A, 48'h80_81_82_83_84_85, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd9,   8'h01, 48'h30_30_30_31_00_01, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h02, 48'h02_02_02_02_02_02, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h11, 48'h03_04_00_01_02_FF, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h00, 48'h00_00_00_00_00_00, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_CFG,    8'hFF, 7'd0,   8'h00, 48'h0, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'hFF, 48'hFF_FF_FF_FF_FF_FF, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h77, 48'h10_11_12_13_14_15, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_CFG,    8'h00, 7'd0,   8'h00, 48'h0, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'hC3, 48'h01_00_00_00_00_00, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h0F, 48'h00_01_02_03_FE_FF, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00},
    '{ROW_CFG,    ERR_LIMIT_RESET, 7'd0, 8'h00, 48'h0, 0, 8'h00, EV_PRESS, 8'h00},
    '{ROW_REPORT, 8'h00, 7'd8,   8'h00, 48'h55_AA_55_AA_00_00, FROM_MODEL, 8'h00, EV_PRESS,
      8'h00}
  };

  logic  clk;
  logic  rst_n;
  logic  cfg_wr_en;
  code_t cfg_wr_data;

  hbkd_in_if  in_ch ();
  hbkd_out_if out_ch ();

  hid_boot_report_key_diff_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // local copy of the block state
  logic [0:5][7:0] held_keys;
  code_t           err_limit;
  exp_event_t      expected_events [$];
  exp_event_t      seen_event;
  int              errors;
  int              send_calm;
  int              recv_calm;
  bit              hold_outputs;
  logic [0:5][7:0] last_slots;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 24);
    return $urandom_range(0, 6);
  endfunction

  function automatic bit code_among(logic [0:5][7:0] set, code_t code);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (set[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // events for one long report, then the held codes move on; short reports change nothing
  function automatic void diff_keys(input report_t r, output exp_event_t evs [$]);
    code_t was;
    code_t now;
    evs.delete();
    if (r.len < MIN_REPORT_LEN) return;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      was = held_keys[i];
      now = r.slots[i];
      if (was > err_limit && !code_among(r.slots, was))
        evs.push_back('{was, EV_RELEASE, NO_MODIFIERS, 1'b0});
      if (now > err_limit && !code_among(held_keys, now))
        evs.push_back('{now, EV_PRESS, r.mods, 1'b0});
    end
    held_keys = r.slots;
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
  endfunction

  function automatic code_t pick_code();
    int lo;
    int hi;
    lo = (err_limit > 4) ? err_limit - 4 : 0;
    hi = (err_limit < 247) ? err_limit + 8 : 255;
    case ($urandom_range(0, 3))
      0: return code_t'($urandom_range(0, 255));
      1: return code_t'($urandom_range(0, 12));
      default: return code_t'($urandom_range(lo, hi));
    endcase
  endfunction

  // mostly a few keys changing against the last report, some noise and short reports
  function automatic report_t make_report();
    report_t r;
    int      kind;
    kind   = $urandom_range(0, 9);
    r.mods = code_t'($urandom_range(0, 255));
    if (kind == 0) begin
      r.len   = len_t'($urandom_range(0, 7));
      r.slots = 48'({$urandom(), $urandom()});
    end else if (kind == 1) begin
      r.len   = len_t'($urandom_range(8, 127));
      r.slots = 48'({$urandom(), $urandom()});
    end else begin
      r.len   = ($urandom_range(0, 3) == 0) ? len_t'($urandom_range(8, 127)) : MIN_REPORT_LEN;
      r.slots = last_slots;
      repeat ($urandom_range(1, 3)) r.slots[$urandom_range(0, 5)] = pick_code();
    end
    if (r.len >= MIN_REPORT_LEN) last_slots = r.slots;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic send_report(input report_t r, input int fixed_n, input exp_event_t fixed_ev);
    int         gap;
    exp_event_t evs [$];
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.report_length <= r.len;
    in_ch.modifier_bits <= r.mods;
    in_ch.slot_code_0   <= r.slots[0];
    in_ch.slot_code_1   <= r.slots[1];
    in_ch.slot_code_2   <= r.slots[2];
    in_ch.slot_code_3   <= r.slots[3];
    in_ch.slot_code_4   <= r.slots[4];
    in_ch.slot_code_5   <= r.slots[5];
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    diff_keys(r, evs);
    if (fixed_n != FROM_MODEL) begin
      evs.delete();
      if (fixed_n == 1) evs.push_back(fixed_ev);
    end
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  // only while idle: all events out and the pipe drained of event-free requests
  task automatic set_error_limit(input code_t value);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    err_limit = value;
  endtask

  initial begin : report_source
    report_t    r;
    exp_event_t fixed_ev;
    code_t      phase_limit [5];
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.report_length = '0;
    in_ch.modifier_bits = '0;
    in_ch.slot_code_0   = '0;
    in_ch.slot_code_1   = '0;
    in_ch.slot_code_2   = '0;
    in_ch.slot_code_3   = '0;
    in_ch.slot_code_4   = '0;
    in_ch.slot_code_5   = '0;
    held_keys           = '0;
    err_limit           = ERR_LIMIT_RESET;
    last_slots          = '0;
    errors              = 0;
    send_calm           = 0;
    hold_outputs        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_error_limit(dir_rows[i].cfg_value);
      end else begin
        r.len    = dir_rows[i].len;
        r.mods   = dir_rows[i].mods;
        r.slots  = dir_rows[i].slots;
        fixed_ev = '{dir_rows[i].fixed_key, dir_rows[i].fixed_rel, dir_rows[i].fixed_mods,
                     1'b1};
        send_report(r, dir_rows[i].fixed_n, fixed_ev);
      end
    end

    phase_limit = '{ERR_LIMIT_RESET, code_t'($urandom_range(4, 40)), 8'h00, 8'hF0, 8'h03};
    hold_outputs = 1'b1;
    foreach (phase_limit[p]) begin
      if (p > 0) set_error_limit(phase_limit[p]);
      repeat (PHASE_ITEMS) send_report(make_report(), FROM_MODEL, '0);
    end
    in_ch.valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (errors == 0) begin
      $display("[hid_boot_report_key_diff_top] OK");
    end else begin
      $display("[hid_boot_report_key_diff_top] ERROR");
    end
    $finish;
  end

  initial begin : event_sink
    int stall;
    out_ch.ready = 1'b0;
    recv_calm    = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      // long back-pressure so the block fills up and stalls its input
      if (hold_outputs) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_outputs = 1'b0;
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual key %h rel %b mods %h last %b",
                 $time, out_ch.event_key, out_ch.event_release, out_ch.event_modifiers,
                 out_ch.event_last);
      end else begin
        seen_event = expected_events.pop_front();
        check_field("event_key", seen_event.key, out_ch.event_key);
        check_field("event_release", 8'(seen_event.rel), 8'(out_ch.event_release));
        check_field("event_modifiers", seen_event.mods, out_ch.event_modifiers);
        check_field("event_last", 8'(seen_event.last), 8'(out_ch.event_last));
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[hid_boot_report_key_diff_top] ERROR");
    $finish;
  end

endmodule
